// ===== sv/trl_pkg.sv =====
// Package for the turn restriction lookup: opcodes, controller commands and status.
// No dependencies.
package trl_pkg;
  typedef enum logic [1:0] {
    MODE_LOAD_SQUARE = 2'd0,
    MODE_LOAD_NODE   = 2'd1,
    MODE_LOAD_TURN   = 2'd2,
    MODE_QUERY       = 2'd3
  } mode_t;

  localparam logic [0:0] REG_SQUARE_COUNT = 1'b0;
  localparam logic [0:0] REG_NODE_SPAN    = 1'b1;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_CAPTURE,
    CMD_SQ_READ,
    CMD_SQ_SETUP,
    CMD_MAP_READ,
    CMD_MAP_CHECK,
    CMD_PROBE,
    CMD_PROBE_EVAL,
    CMD_NODE_EVAL,
    CMD_TURN_READ,
    CMD_TURN_EVAL,
    CMD_MARK,
    CMD_CLEAR
  } cmd_t;

  typedef struct packed {
    logic is_load;
    logic uturn;
    logic sq_ok;
    logic map_hit;
    logic search_done;
    logic found;
    logic turns_zero;
    logic turn_match;
    logic turn_last;
    logic covered;
    logic clear_done;
  } stat_t;
endpackage

// ===== sv/trl_datapath.sv =====
// Datapath of the turn restriction lookup: table memories, no-turn bitmap, search registers.
// Depends on trl_pkg.
module trl_datapath import trl_pkg::*; #(
  parameter int SQUARE_DEPTH = 1024,
  parameter int NODE_DEPTH   = 4096,
  parameter int TURN_DEPTH   = 4096,
  parameter int NODE_SPAN    = 65536
) (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  input  logic [1:0]         mode,
  input  logic [11:0]        slot,
  input  logic [9:0]         square,
  input  logic [15:0]        node,
  input  logic signed [23:0] inbound_line,
  input  logic signed [23:0] to_line,
  input  logic [11:0]        first_index,
  input  logic [12:0]        entry_count,
  input  logic [10:0]        square_count,
  input  logic [16:0]        node_cache_span,
  output stat_t              stat
);
  localparam int SAW = (SQUARE_DEPTH > 1) ? $clog2(SQUARE_DEPTH) : 1;
  localparam int NAW = (NODE_DEPTH > 1) ? $clog2(NODE_DEPTH) : 1;
  localparam int TAW = (TURN_DEPTH > 1) ? $clog2(TURN_DEPTH) : 1;
  localparam int MWORDS = (NODE_SPAN + 31) / 32;
  localparam int MAW = (MWORDS > 1) ? $clog2(MWORDS) : 1;
  localparam int IW = 22;

  logic [24:0] sq_mem [SQUARE_DEPTH];
  logic [40:0] node_mem [NODE_DEPTH];
  logic [47:0] turn_mem [TURN_DEPTH];
  logic [31:0] map_mem [MWORDS];

  logic [1:0]  q_mode;
  logic [11:0] q_slot;
  logic [9:0]  q_square;
  logic [15:0] q_node;
  logic [23:0] q_from, q_to;
  logic [11:0] q_fi;
  logic [12:0] q_cnt;
  logic [24:0] f_mag, t_mag;

  logic [24:0] sq_rd;
  logic [40:0] node_rd;
  logic [47:0] turn_rd;
  logic [31:0] map_rd;
  logic signed [IW-1:0] first, last, lo, hi, mid, ti, tl;
  logic [MAW-1:0] clr_addr;

  logic signed [IW-1:0] last_raw, tl_raw;
  logic covered_c;

  assign f_mag = q_from[23] ? 25'd0 - {q_from[23], q_from} : {1'b0, q_from};
  assign t_mag = q_to[23] ? 25'd0 - {q_to[23], q_to} : {1'b0, q_to};
  assign covered_c = ({1'b0, q_node} < node_cache_span) &&
                     (32'(q_node) < 32'(NODE_SPAN));
  assign last_raw = IW'(sq_rd[24:13]) + IW'(sq_rd[12:0]) - IW'(1);
  assign tl_raw = IW'(node_rd[24:13]) + IW'(node_rd[12:0]) - IW'(1);

  always_ff @(posedge clk) begin
    unique case (cmd)
      CMD_CAPTURE: begin
        q_mode <= mode; q_slot <= slot; q_square <= square; q_node <= node;
        q_from <= inbound_line; q_to <= to_line; q_fi <= first_index; q_cnt <= entry_count;
      end
      CMD_SQ_READ: begin
        if (q_mode == MODE_LOAD_SQUARE && 32'(q_slot) < 32'(SQUARE_DEPTH))
          sq_mem[q_slot[SAW-1:0]] <= {q_fi, q_cnt};
        if (q_mode == MODE_LOAD_NODE && 32'(q_slot) < 32'(NODE_DEPTH))
          node_mem[q_slot[NAW-1:0]] <= {q_node, q_fi, q_cnt};
        if (q_mode == MODE_LOAD_TURN && 32'(q_slot) < 32'(TURN_DEPTH))
          turn_mem[q_slot[TAW-1:0]] <= {q_from, q_to};
        sq_rd <= sq_mem[q_square[SAW-1:0]];
      end
      CMD_SQ_SETUP: begin
        first <= IW'(sq_rd[24:13]);
        last <= (last_raw > IW'(NODE_DEPTH - 1)) ? IW'(NODE_DEPTH - 1) : last_raw;
        lo <= IW'(sq_rd[24:13]) - IW'(1);
        hi <= last_raw + IW'(1);
        if (last_raw + IW'(1) > IW'(NODE_DEPTH)) hi <= IW'(NODE_DEPTH);
      end
      CMD_MAP_READ: map_rd <= map_mem[MAW'(q_node >> 5)];
      CMD_PROBE: begin
        mid <= (lo + hi) >>> 1;
        node_rd <= node_mem[NAW'((lo + hi) >>> 1)];
      end
      CMD_PROBE_EVAL: begin
        if (q_node < node_rd[40:25]) hi <= mid;
        else if (q_node > node_rd[40:25]) lo <= mid;
        else begin hi <= mid; lo <= mid; end
      end
      CMD_NODE_EVAL: node_rd <= node_mem[NAW'(hi)];
      CMD_TURN_READ: begin
        if (ti == IW'(-1)) begin
          ti <= IW'(node_rd[24:13]);
          tl <= (tl_raw > IW'(TURN_DEPTH - 1)) ? IW'(TURN_DEPTH - 1) : tl_raw;
          turn_rd <= turn_mem[TAW'(node_rd[24:13])];
        end else begin
          turn_rd <= turn_mem[TAW'(ti)];
        end
      end
      CMD_TURN_EVAL: ti <= ti + IW'(1);
      CMD_MARK: map_mem[MAW'(q_node >> 5)] <= map_rd | (32'(1) << q_node[4:0]);
      CMD_CLEAR: map_mem[clr_addr] <= '0;
      default: ;
    endcase
    if (cmd == CMD_NODE_EVAL || cmd == CMD_CAPTURE) ti <= IW'(-1);
  end

  always_ff @(posedge clk) begin
    if (rst) clr_addr <= '0;
    else if (cmd == CMD_CLEAR) clr_addr <= clr_addr + MAW'(1);
  end

  always_comb begin
    stat = '0;
    stat.is_load = q_mode != MODE_QUERY;
    stat.uturn = f_mag == t_mag;
    stat.sq_ok = ({1'b0, q_square} < square_count) &&
                 (32'(q_square) < 32'(SQUARE_DEPTH)) && (sq_rd[12:0] != '0);
    stat.map_hit = covered_c && map_rd[q_node[4:0]];
    stat.search_done = (hi - lo <= IW'(1)) || (lo == hi);
    stat.found = (hi <= last) && (hi >= first) && (node_rd[40:25] == q_node);
    stat.turns_zero = node_rd[12:0] == '0;
    stat.turn_match = ({turn_rd[47], turn_rd[47:24]} == f_mag) &&
                      ({turn_rd[23], turn_rd[23:0]} == t_mag);
    stat.turn_last = ti >= tl;
    stat.covered = covered_c;
    stat.clear_done = 32'(clr_addr) == 32'(MWORDS - 1);
  end
endmodule

// ===== sv/trl_ctrl.sv =====
// Controller of the turn restriction lookup: sequences load, search, scan and map clear.
// Depends on trl_pkg.
module trl_ctrl import trl_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  stat_t stat,
  output cmd_t  cmd,
  output logic  busy,
  output logic  done,
  output logic  restricted
);
  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_SQ, S_SETUP, S_MAP, S_CHECK, S_PROBE, S_EVAL,
    S_NODE, S_NCHK, S_TREAD, S_TEVAL, S_MARK
  } state_t;
  state_t state;

  always_comb begin
    unique case (state)
      S_CLEAR: cmd = CMD_CLEAR;
      S_IDLE:  cmd = start ? CMD_CAPTURE : CMD_NONE;
      S_SQ:    cmd = CMD_SQ_READ;
      S_SETUP: cmd = CMD_SQ_SETUP;
      S_MAP:   cmd = CMD_MAP_READ;
      S_CHECK: cmd = CMD_MAP_CHECK;
      S_PROBE: cmd = stat.search_done ? CMD_NODE_EVAL : CMD_PROBE;
      S_EVAL:  cmd = CMD_PROBE_EVAL;
      S_NODE:  cmd = CMD_NONE;
      S_NCHK:  cmd = (stat.found && !stat.turns_zero) ? CMD_TURN_READ : CMD_NONE;
      S_TREAD: cmd = CMD_TURN_READ;
      S_TEVAL: cmd = CMD_TURN_EVAL;
      S_MARK:  cmd = CMD_MARK;
      default: cmd = CMD_NONE;
    endcase
  end

  assign busy = state != S_IDLE;

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      state <= S_CLEAR;
      restricted <= 1'b0;
    end else begin
      unique case (state)
        S_CLEAR: if (stat.clear_done) state <= S_IDLE;
        S_IDLE:  if (start) state <= S_SQ;
        S_SQ: begin
          if (stat.is_load) state <= S_IDLE;
          else if (stat.uturn) begin
            done <= 1'b1; restricted <= 1'b1; state <= S_IDLE;
          end else state <= S_SETUP;
        end
        S_SETUP: begin
          if (!stat.sq_ok) begin
            done <= 1'b1; restricted <= 1'b0; state <= S_IDLE;
          end else state <= S_MAP;
        end
        S_MAP: state <= S_CHECK;
        S_CHECK: begin
          if (stat.map_hit) begin
            done <= 1'b1; restricted <= 1'b0; state <= S_IDLE;
          end else state <= S_PROBE;
        end
        S_PROBE: state <= stat.search_done ? S_NODE : S_EVAL;
        S_EVAL:  state <= S_PROBE;
        S_NODE:  state <= S_NCHK;
        S_NCHK: begin
          if (!stat.found) begin
            if (stat.covered) state <= S_MARK;
            else begin done <= 1'b1; restricted <= 1'b0; state <= S_IDLE; end
          end else if (stat.turns_zero) begin
            done <= 1'b1; restricted <= 1'b0; state <= S_IDLE;
          end else state <= S_TEVAL;
        end
        S_TREAD: state <= S_TEVAL;
        S_TEVAL: begin
          if (stat.turn_match) begin
            done <= 1'b1; restricted <= 1'b1; state <= S_IDLE;
          end else if (stat.turn_last) begin
            done <= 1'b1; restricted <= 1'b0; state <= S_IDLE;
          end else state <= S_TREAD;
        end
        S_MARK: begin done <= 1'b1; restricted <= 1'b0; state <= S_IDLE; end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> state == S_IDLE)
    else $error("result without return to idle");
  a_no_start_busy: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && start) |=> busy)
    else $error("accepted item did not start work");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe longer than one cycle");
`endif
endmodule

// ===== sv/turn_restriction_lookup_top.sv =====
// Top level of the turn restriction lookup: APB registers, controller and datapath.
// Depends on trl_pkg, trl_ctrl, trl_datapath.
//
// Accepts one item when start is high and busy is low. A query reads the square table,
// checks the no-turn bitmap, then runs a binary search of the node memory and a scan of
// the turn list through single-port reads; a miss in the covered range is marked in the
// bitmap. After reset, busy stays high while the no-turn bitmap is cleared. Results appear
// on done for one cycle and cannot be stalled.
module turn_restriction_lookup_top import trl_pkg::*; #(
  parameter int SQUARE_DEPTH = 1024,
  parameter int NODE_DEPTH   = 4096,
  parameter int TURN_DEPTH   = 4096,
  parameter int NODE_SPAN    = 65536
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         mode,
  input  logic [11:0]        slot,
  input  logic [9:0]         square,
  input  logic [15:0]        node,
  input  logic signed [23:0] inbound_line,
  input  logic signed [23:0] to_line,
  input  logic [11:0]        first_index,
  input  logic [12:0]        entry_count,
  output logic               done,
  output logic               restricted
);
  logic [10:0] square_count;
  logic [16:0] node_cache_span;
  cmd_t  cmd;
  stat_t stat;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      square_count <= '0;
      node_cache_span <= '0;
    end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
      if (paddr[2] == REG_SQUARE_COUNT) square_count <= pwdata[10:0];
      if (paddr[2] == REG_NODE_SPAN) node_cache_span <= pwdata[16:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[1:0] == 2'b00) begin
      if (paddr[2] == REG_SQUARE_COUNT) prdata = 32'(square_count);
      else prdata = 32'(node_cache_span);
    end
  end

  trl_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .stat(stat), .cmd(cmd),
    .busy(busy), .done(done), .restricted(restricted)
  );

  trl_datapath #(
    .SQUARE_DEPTH(SQUARE_DEPTH), .NODE_DEPTH(NODE_DEPTH),
    .TURN_DEPTH(TURN_DEPTH), .NODE_SPAN(NODE_SPAN)
  ) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .mode(mode), .slot(slot), .square(square),
    .node(node), .inbound_line(inbound_line), .to_line(to_line),
    .first_index(first_index), .entry_count(entry_count), .square_count(square_count),
    .node_cache_span(node_cache_span), .stat(stat)
  );
endmodule
